>>> rtl/urhb_pkg.sv
// shared types and constants for the undo/redo history buffer
// no dependencies; imported by the controller, datapath and top level

package urhb_pkg;

  localparam int HistDepth = 16;
  localparam int WORD_BITS = 32;
  localparam int PTR_W     = $clog2(HistDepth);
  localparam int CNT_W     = $clog2(HistDepth + 1);
  localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;
  localparam int FUNC_BITS = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    OP_PUSH = 2'd0,
    OP_UNDO = 2'd1,
    OP_REDO = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;   // capture the input beat
    logic read;   // register the two memory reads
    logic exec;   // update state and load the output register
  } cmd_t;

  typedef struct packed {
    logic out_busy;  // output register holds a beat that is not taken this cycle
  } status_t;

endpackage

>>> rtl/undo_redo_history_buffer_unit.sv
// undo/redo history buffer: 16-entry action ring with valid marks and a redo stack
// steps per beat: capture, memory read, execute, then the result is held in the output register
// a new beat is taken only after the last one has executed; the ring and stack reads are registered
// a result waiting on the output stalls the execute step, and with it the next capture
// reset (rst, synchronous): clears valid marks, position, redo count and output valid
// depends on urhb_pkg, urhb_ctrl and urhb_datapath

module undo_redo_history_buffer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [urhb_pkg::TDATA_BITS-1:0] s_tdata,   // action_word
  input  logic [urhb_pkg::FUNC_BITS-1:0]  s_tuser,   // func
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [urhb_pkg::TDATA_BITS-1:0] m_tdata,   // action_out
  output logic [0:0]                    m_tuser    // ok
);
  import urhb_pkg::*;

  cmd_t                 cmd;
  status_t              status;
  logic                 res_ok;
  logic [WORD_BITS-1:0] res_word;

  urhb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  urhb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_func   (s_tuser),
    .in_word   (s_tdata[WORD_BITS-1:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ok    (res_ok),
    .out_word  (res_word)
  );

  assign m_tdata = TDATA_BITS'(res_word);
  assign m_tuser = res_ok;

endmodule

>>> rtl/urhb_ctrl.sv
// sequencer for the undo/redo history buffer: capture, read, execute
// depends on urhb_pkg

module urhb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  urhb_pkg::status_t status,
  output urhb_pkg::cmd_t    cmd
);
  import urhb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_EXEC: begin
        cmd.exec = !status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == ST_READ)
    else $error("capture not followed by read");
  assert property (@(posedge clk) disable iff (rst) cmd.read |=> state == ST_EXEC)
    else $error("read not followed by execute");
  assert property (@(posedge clk) disable iff (rst) cmd.exec |-> !status.out_busy)
    else $error("execute while output register is occupied");

endmodule

>>> rtl/urhb_datapath.sv
// history ring, valid marks, redo stack, pointers and output register
// depends on urhb_pkg; driven by urhb_ctrl commands

module urhb_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  urhb_pkg::cmd_t               cmd,
  output urhb_pkg::status_t            status,
  input  logic [urhb_pkg::FUNC_BITS-1:0] in_func,
  input  logic [urhb_pkg::WORD_BITS-1:0] in_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ok,
  output logic [urhb_pkg::WORD_BITS-1:0] out_word
);
  import urhb_pkg::*;

  logic [WORD_BITS-1:0] hist_mem [HistDepth];
  logic [WORD_BITS-1:0] redo_mem [HistDepth];
  logic [HistDepth-1:0] hist_valid;
  logic [PTR_W-1:0]     pos;
  logic [CNT_W-1:0]     redo_cnt;

  op_t                  op;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] hist_rd;
  logic [WORD_BITS-1:0] redo_rd;

  logic [PTR_W-1:0]     pos_prev;
  logic [PTR_W-1:0]     pos_succ;
  logic [CNT_W-1:0]     cnt_dec;

  logic                 do_push;
  logic                 do_undo;
  logic                 do_redo;
  logic                 hist_we;
  logic [WORD_BITS-1:0] hist_wdata;

  assign pos_prev = (pos == '0) ? PTR_W'(HistDepth - 1) : pos - 1'b1;
  assign pos_succ = (pos == PTR_W'(HistDepth - 1)) ? '0 : pos + 1'b1;
  assign cnt_dec  = redo_cnt - 1'b1;

  assign do_push = cmd.exec && (op == OP_PUSH);
  assign do_undo = cmd.exec && (op == OP_UNDO) && hist_valid[pos_prev]
                   && (redo_cnt < CNT_W'(HistDepth));
  assign do_redo = cmd.exec && (op == OP_REDO) && (redo_cnt != '0);

  assign hist_we    = do_push || do_redo;
  assign hist_wdata = do_push ? word : redo_rd;

  assign status.out_busy = out_valid && !out_ready;

  // captured beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= op_t'(in_func);
      word <= in_word;
    end
  end

  // ring and redo stack storage, one write and one registered read each
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[pos] <= hist_wdata;
    if (cmd.read) hist_rd <= hist_mem[pos_prev];
  end

  always_ff @(posedge clk) begin
    if (do_undo) redo_mem[redo_cnt[PTR_W-1:0]] <= hist_rd;
    if (cmd.read) redo_rd <= redo_mem[cnt_dec[PTR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
      pos        <= '0;
      redo_cnt   <= '0;
    end else begin
      if (do_push) begin
        hist_valid[pos] <= 1'b1;
        pos             <= pos_succ;
        redo_cnt        <= '0;
      end else if (do_undo) begin
        hist_valid[pos_prev] <= 1'b0;
        pos                  <= pos_prev;
        redo_cnt             <= redo_cnt + 1'b1;
      end else if (do_redo) begin
        hist_valid[pos] <= 1'b1;
        pos             <= pos_succ;
        redo_cnt        <= cnt_dec;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_ok <= do_push || do_undo || do_redo;
      if (do_undo) begin
        out_word <= hist_rd;
      end else if (do_redo) begin
        out_word <= redo_rd;
      end else begin
        out_word <= '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) redo_cnt <= CNT_W'(HistDepth))
    else $error("redo stack count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
      do_push |=> redo_cnt == '0 && hist_valid[$past(pos)])
    else $error("push did not clear redo stack or mark slot");
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ok |-> out_word == '0)
    else $error("refused operation returned a non-zero word");
  assert property (@(posedge clk) disable iff (rst)
      do_undo |=> !hist_valid[pos] && redo_cnt == $past(redo_cnt) + 1'b1)
    else $error("undo did not release slot or grow redo stack");

endmodule
